@@ rtl/core/bscs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bscs_pkg
// Shared sizes, operation codes and controller/datapath interface types for
// the bitmap set/count/scan unit.
// ----------------------------------------------------------------------------
package bscs_pkg;

    // Store geometry (WORD_BITS must be a power of two)
    localparam int WORD_BITS = 64;
    localparam int NUM_WORDS = 16;
    localparam int CAPACITY  = NUM_WORDS * WORD_BITS;

    // Field widths
    localparam int OP_W  = 3;
    localparam int IDX_W = 10;
    localparam int CFG_W = 11;
    localparam int CNT_OUT_W = 11;

    // Derived widths
    localparam int WB_LOG = $clog2(WORD_BITS);
    localparam int WIDX_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int PC_W   = $clog2(WORD_BITS + 1);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int LIM_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

    // Operation codes
    localparam logic [OP_W-1:0] OP_WRITE     = 3'd0;
    localparam logic [OP_W-1:0] OP_TEST      = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR_ALL = 3'd2;
    localparam logic [OP_W-1:0] OP_COUNT     = 3'd3;
    localparam logic [OP_W-1:0] OP_FIRST_FWD = 3'd4;
    localparam logic [OP_W-1:0] OP_NEXT_FWD  = 3'd5;
    localparam logic [OP_W-1:0] OP_FIRST_REV = 3'd6;
    localparam logic [OP_W-1:0] OP_NEXT_REV  = 3'd7;

    typedef struct packed {
        logic latch;
        logic exec;
        logic walk;
    } t_cmd;

    typedef struct packed {
        logic need_walk;
        logic walk_end;
    } t_stat;

endpackage : bscs_pkg
`default_nettype wire

@@ rtl/core/bscs_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bscs_ctrl
// Request sequencer: accept, execute, optional word walk, then
// a one-cycle result strobe.
// ----------------------------------------------------------------------------
module bscs_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire bscs_pkg::t_stat i_stat,
    output bscs_pkg::t_cmd     o_cmd,
    output logic               busy,
    output logic               o_done
);
    import bscs_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = i_stat.need_walk ? S_WALK : S_DONE;
            end
            S_WALK: begin
                if (i_stat.walk_end) n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.latch = (r_state == S_IDLE) && start;
    assign o_cmd.exec  = (r_state == S_EXEC);
    assign o_cmd.walk  = (r_state == S_WALK);
    assign busy        = (r_state != S_IDLE);
    assign o_done      = (r_state == S_DONE);

endmodule : bscs_ctrl
`default_nettype wire

@@ rtl/core/bscs_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bscs_dp
// Bitmap store, scan state, count accumulator and result formatting.
// ----------------------------------------------------------------------------
module bscs_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire bscs_pkg::t_cmd                 i_cmd,
    output bscs_pkg::t_stat                     o_stat,
    input  wire logic                           i_cfg_we,
    input  wire logic [bscs_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  wire logic [bscs_pkg::OP_W-1:0]      i_operation,
    input  wire logic [bscs_pkg::IDX_W-1:0]     i_bit_index,
    input  wire logic                           i_bit_value,
    output logic                                o_bit_found,
    output logic [bscs_pkg::IDX_W-1:0]          o_found_index,
    output logic [bscs_pkg::CNT_OUT_W-1:0]      o_set_count,
    output logic [bscs_pkg::CNT_OUT_W-1:0]      o_clear_count,
    output logic                                o_status
);
    import bscs_pkg::*;

    localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(NUM_WORDS - 1);
    localparam logic [WIDX_W-1:0] ZERO_WORD = '0;

    function automatic logic [WB_LOG-1:0] low_pos(input logic [WORD_BITS-1:0] v);
        logic [WB_LOG-1:0] p;
        p = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) p = WB_LOG'(i);
        end
        return p;
    endfunction

    function automatic logic [WB_LOG-1:0] high_pos(input logic [WORD_BITS-1:0] v);
        logic [WB_LOG-1:0] p;
        p = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (v[i]) p = WB_LOG'(i);
        end
        return p;
    endfunction

    logic [WORD_BITS-1:0] r_words [NUM_WORDS];

    logic [CFG_W-1:0]     r_bits_in_use;
    logic [OP_W-1:0]      r_op;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_val;
    logic [WIDX_W-1:0]    r_ptr, n_ptr;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [WIDX_W-1:0]    r_scan_word, n_scan_word;
    logic [WORD_BITS-1:0] r_scan_rem, n_scan_rem;
    logic                 r_found, n_found;
    logic                 r_status, n_status;

    logic [LIM_W-1:0]     lim;
    logic                 idx_ok;
    logic [IDX_W-1:0]     word_full;
    logic [WIDX_W-1:0]    wsel;
    logic [WB_LOG-1:0]    bsel;
    logic [WIDX_W-1:0]    rd_addr;
    logic [WORD_BITS-1:0] rd_word;
    logic                 rd_nz;
    logic                 is_count;
    logic                 is_rev;
    logic                 wr_en;
    logic                 clr_all;
    logic [WORD_BITS-1:0] rem_fwd;
    logic [WORD_BITS-1:0] rem_rev;
    logic [WORD_BITS-1:0] hi_mask;
    logic [WB_LOG-1:0]    pos;
    logic [WIDX_W+WB_LOG-1:0] full_index;
    logic [LIM_W-1:0]     cnt_ext;
    logic [LIM_W-1:0]     clr_val;

    // index check against min(bits_in_use, capacity)
    assign lim = (LIM_W'(r_bits_in_use) > LIM_W'(CAPACITY)) ? LIM_W'(CAPACITY)
                                                            : LIM_W'(r_bits_in_use);
    assign idx_ok    = LIM_W'(r_idx) < lim;
    assign word_full = r_idx >> WB_LOG;
    assign wsel      = WIDX_W'(word_full);
    assign bsel      = WB_LOG'(r_idx);

    assign rd_addr = i_cmd.exec ? wsel : r_ptr;
    assign rd_word = r_words[rd_addr];
    assign rd_nz   = |rd_word;

    assign is_count = (r_op == OP_COUNT);
    assign is_rev   = (r_op == OP_FIRST_REV) || (r_op == OP_NEXT_REV);

    assign wr_en   = i_cmd.exec && (r_op == OP_WRITE) && idx_ok;
    assign clr_all = i_cmd.exec && (r_op == OP_CLEAR_ALL);

    assign rem_fwd = r_scan_rem & (r_scan_rem - WORD_BITS'(1));
    assign hi_mask = WORD_BITS'(1) << high_pos(r_scan_rem);
    assign rem_rev = r_scan_rem & ~hi_mask;

    always_comb begin
        n_ptr       = r_ptr;
        n_cnt       = r_cnt;
        n_scan_word = r_scan_word;
        n_scan_rem  = r_scan_rem;
        n_found     = r_found;
        n_status    = r_status;
        o_stat.need_walk = 1'b0;
        o_stat.walk_end  = 1'b0;

        if (i_cmd.exec) begin
            n_found  = 1'b0;
            n_status = 1'b0;
            unique case (r_op)
                OP_WRITE: begin
                    n_status = !idx_ok;
                end
                OP_TEST: begin
                    n_status = !idx_ok;
                    n_found  = idx_ok && rd_word[bsel];
                end
                OP_CLEAR_ALL: begin
                end
                OP_COUNT: begin
                    n_ptr = ZERO_WORD;
                    n_cnt = '0;
                    o_stat.need_walk = 1'b1;
                end
                OP_FIRST_FWD: begin
                    n_ptr = ZERO_WORD;
                    o_stat.need_walk = 1'b1;
                end
                OP_FIRST_REV: begin
                    n_ptr = LAST_WORD;
                    o_stat.need_walk = 1'b1;
                end
                OP_NEXT_FWD: begin
                    if (r_scan_rem != '0) begin
                        n_scan_rem = rem_fwd;
                        if (rem_fwd == '0 && r_scan_word != LAST_WORD) begin
                            n_ptr = r_scan_word + WIDX_W'(1);
                            o_stat.need_walk = 1'b1;
                        end
                    end
                end
                OP_NEXT_REV: begin
                    if (r_scan_rem != '0) begin
                        n_scan_rem = rem_rev;
                        if (rem_rev == '0 && r_scan_word != ZERO_WORD) begin
                            n_ptr = r_scan_word - WIDX_W'(1);
                            o_stat.need_walk = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.walk) begin
            if (is_count) begin
                n_cnt = r_cnt + CNT_W'($countones(rd_word));
                n_ptr = r_ptr + WIDX_W'(1);
                o_stat.walk_end = (r_ptr == LAST_WORD);
            end else begin
                o_stat.walk_end = rd_nz || (is_rev ? (r_ptr == ZERO_WORD)
                                                   : (r_ptr == LAST_WORD));
                if (rd_nz) begin
                    n_scan_word = r_ptr;
                    n_scan_rem  = rd_word;
                end else if (o_stat.walk_end) begin
                    n_scan_rem = '0;
                end else begin
                    n_ptr = is_rev ? (r_ptr - WIDX_W'(1)) : (r_ptr + WIDX_W'(1));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_WORDS; i++) r_words[i] <= '0;
        end else if (clr_all) begin
            for (int i = 0; i < NUM_WORDS; i++) r_words[i] <= '0;
        end else if (wr_en) begin
            r_words[wsel][bsel] <= r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits_in_use <= CFG_RESET;
            r_scan_word   <= '0;
            r_scan_rem    <= '0;
        end else begin
            if (i_cfg_we) r_bits_in_use <= i_cfg_wdata;
            r_scan_word <= n_scan_word;
            r_scan_rem  <= n_scan_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op  <= i_operation;
            r_idx <= i_bit_index;
            r_val <= i_bit_value;
        end
        r_ptr    <= n_ptr;
        r_cnt    <= n_cnt;
        r_found  <= n_found;
        r_status <= n_status;
    end

    // result formatting
    assign pos        = is_rev ? high_pos(r_scan_rem) : low_pos(r_scan_rem);
    assign full_index = {r_scan_word, pos};
    assign cnt_ext    = LIM_W'(r_cnt);
    assign clr_val    = (lim > cnt_ext) ? (lim - cnt_ext) : '0;

    always_comb begin
        o_bit_found   = r_found;
        o_found_index = '0;
        o_set_count   = '0;
        o_clear_count = '0;
        o_status      = r_status;
        if (r_op[OP_W-1]) begin
            o_bit_found = |r_scan_rem;
            o_status    = 1'b0;
            if (|r_scan_rem) o_found_index = IDX_W'(full_index);
        end else if (is_count) begin
            o_bit_found   = 1'b0;
            o_status      = 1'b0;
            o_set_count   = CNT_OUT_W'(r_cnt);
            o_clear_count = CNT_OUT_W'(clr_val);
        end
    end

endmodule : bscs_dp
`default_nettype wire

@@ rtl/core/bitmap_set_count_scan_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_set_count_scan_unit
// Bitmap of NUM_WORDS words: bit write/test, clear, population count and
// forward/reverse set-bit scan, one request at a time.
// ----------------------------------------------------------------------------
// Each request is latched and executed; count, and a scan that must find a
// new word, then walk the store one word read at a time (count reads every
// word) before o_done pulses. busy stays high through the o_done cycle, so
// a new request is accepted only once busy is low again.
// The receiver cannot stall. Synchronous reset clears store and scan state.
module bitmap_set_count_scan_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [bscs_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [bscs_pkg::OP_W-1:0]     i_operation,
    input  wire logic [bscs_pkg::IDX_W-1:0]    i_bit_index,
    input  wire logic                          i_bit_value,
    output logic                               o_done,
    output logic                               o_bit_found,
    output logic [bscs_pkg::IDX_W-1:0]         o_found_index,
    output logic [bscs_pkg::CNT_OUT_W-1:0]     o_set_count,
    output logic [bscs_pkg::CNT_OUT_W-1:0]     o_clear_count,
    output logic                               o_status
);
    import bscs_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    bscs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_done  (o_done)
    );

    bscs_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_operation   (i_operation),
        .i_bit_index   (i_bit_index),
        .i_bit_value   (i_bit_value),
        .o_bit_found   (o_bit_found),
        .o_found_index (o_found_index),
        .o_set_count   (o_set_count),
        .o_clear_count (o_clear_count),
        .o_status      (o_status)
    );

endmodule : bitmap_set_count_scan_unit
`default_nettype wire
